// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the reset argument is high
`define ASSERT_IMPLIES(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Next-cycle implication, disabled while the reset argument is high
`define ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ===== rtl/lrc_pkg.sv =====
// Package for the LED ring clock hand renderer: sizes, register indexes,
// divider state and status types. Depends on nothing.
`default_nettype none
package lrc_pkg;

  localparam int LED_COUNT = 60;
  localparam int FRAC_BITS = 8;

  localparam int LED_W  = $clog2(LED_COUNT);
  localparam int LVL_W  = FRAC_BITS + 1;
  localparam int CLK_W  = 25;
  localparam int QUO_W  = LED_W + FRAC_BITS;
  localparam int NUM_W  = CLK_W + QUO_W;
  localparam int CNT_W  = $clog2(CLK_W);
  localparam int HUE_W  = 9;

  localparam int HUE_WRAP      = 360;
  localparam int SEC_PER_MIN   = 60;
  localparam int SEC_PER_HOUR  = 3600;
  localparam int HOURS_HALF    = 12;
  localparam int HOURS_FULL    = 24;

  // Configuration register indexes
  localparam logic [2:0] REG_TICKS      = 3'd0;
  localparam logic [2:0] REG_SECOND_HUE = 3'd1;
  localparam logic [2:0] REG_MINUTE_HUE = 3'd2;
  localparam logic [2:0] REG_HOUR_HUE   = 3'd3;
  localparam logic [2:0] REG_BRIGHTNESS = 3'd4;
  localparam logic [2:0] REG_SATURATION = 3'd5;
  localparam logic [2:0] REG_DAY_MODE   = 3'd6;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_MOD,
    DIV_QUO,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    logic idle;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

// ===== rtl/lrc_hand_div.sv =====
// Hand placement unit: bit-serial clk mod span, then a shifted-divisor
// quotient of that remainder scaled to LED positions. Depends on lrc_pkg.
`default_nettype none
module lrc_hand_div import lrc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             take,
  input  wire logic [CLK_W-1:0] clk_count,
  input  wire logic [CLK_W-1:0] span,
  output div_status_t           status,
  output logic [LED_W-1:0]      pos,
  output logic [LED_W-1:0]      nxt,
  output logic [LVL_W-1:0]      lvl_pos,
  output logic [LVL_W-1:0]      lvl_nxt
);

  div_state_t state, state_next;

  logic [CLK_W-1:0] num;
  logic [CLK_W-1:0] rem;
  logic [CLK_W-1:0] div;
  logic [NUM_W-1:0] x;
  logic [NUM_W-1:0] dsh;
  logic [QUO_W-1:0] quo;
  logic [CNT_W-1:0] cnt;

  logic [CLK_W:0]   trial;
  logic [CLK_W-1:0] rem_step;
  logic             x_ge;

  // One restoring step of the remainder
  assign trial    = {rem, num[CLK_W-1]};
  assign rem_step = (trial >= {1'b0, div}) ? CLK_W'(trial - {1'b0, div})
                                           : trial[CLK_W-1:0];
  assign x_ge     = (x >= dsh);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: if (start) state_next = DIV_MOD;
      DIV_MOD:  if (cnt == '0) state_next = DIV_QUO;
      DIV_QUO:  if (cnt == '0) state_next = DIV_DONE;
      DIV_DONE: if (take) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  // Status outputs
  always_comb begin
    status.idle = (state == DIV_IDLE);
    status.done = (state == DIV_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: load, reduce modulo span, then extract the scaled quotient
  always_ff @(posedge clk) begin
    case (state)
      DIV_IDLE: begin
        if (start) begin
          num <= clk_count;
          rem <= '0;
          div <= span;
          cnt <= CNT_W'(CLK_W - 1);
        end
      end
      DIV_MOD: begin
        rem <= rem_step;
        num <= {num[CLK_W-2:0], 1'b0};
        if (cnt == '0) begin
          x   <= (NUM_W'(rem_step) * NUM_W'(LED_COUNT)) << FRAC_BITS;
          dsh <= NUM_W'(div) << (QUO_W - 1);
          quo <= '0;
          cnt <= CNT_W'(QUO_W - 1);
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      DIV_QUO: begin
        if (x_ge) begin
          x <= x - dsh;
        end
        quo <= {quo[QUO_W-2:0], x_ge};
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Hand position and intensities from the quotient
  assign pos     = quo[QUO_W-1:FRAC_BITS];
  assign nxt     = (pos == LED_W'(LED_COUNT - 1)) ? '0 : pos + 1'b1;
  assign lvl_nxt = {1'b0, quo[FRAC_BITS-1:0]};
  assign lvl_pos = LVL_W'(1 << FRAC_BITS) - lvl_nxt;

endmodule
`default_nettype wire

// ===== rtl/led_ring_clock_hand_renderer_unit.sv =====
// LED ring clock hand renderer: one transaction in, 60 HSV pixels out.
// The pixel emitter, which out_ready can stall, paces the frames; the next
// tick's placement overlaps the frame being drawn.
// Reset (rst, synchronous): clears all valid bits and loads register defaults.
`default_nettype none
module led_ring_clock_hand_renderer_unit import lrc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [2:0] cfg_index,
  input  wire logic [8:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [4:0] hour_of_day,
  input  wire logic [5:0] minute_of_hour,
  input  wire logic [5:0] second_of_minute,
  input  wire logic [7:0] tick_in_second,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [5:0]      pixel_index,
  output logic [8:0]      hue,
  output logic [7:0]      saturation,
  output logic [7:0]      brightness_value,
  output logic            last_pixel
);

  localparam int PRD_W = LVL_W + HUE_W;
  localparam int SUM_W = PRD_W + 2;
  localparam int HSH_W = SUM_W - FRAC_BITS;
  localparam int VPR_W = LVL_W + 8;

  // Configuration registers
  logic [7:0]       ticks_per_second;
  logic [HUE_W-1:0] second_hue;
  logic [HUE_W-1:0] minute_hue;
  logic [HUE_W-1:0] hour_hue;
  logic [7:0]       peak_brightness;
  logic [7:0]       pixel_saturation;
  logic             day_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= 8'd25;
      second_hue       <= 9'd0;
      minute_hue       <= 9'd120;
      hour_hue         <= 9'd240;
      peak_brightness  <= 8'd255;
      pixel_saturation <= 8'd255;
      day_mode         <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TICKS:      ticks_per_second <= cfg_data[7:0];
        REG_SECOND_HUE: second_hue       <= cfg_data;
        REG_MINUTE_HUE: minute_hue       <= cfg_data;
        REG_HOUR_HUE:   hour_hue         <= cfg_data;
        REG_BRIGHTNESS: peak_brightness  <= cfg_data[7:0];
        REG_SATURATION: pixel_saturation <= cfg_data[7:0];
        REG_DAY_MODE:   day_mode         <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign saturation = pixel_saturation;

  // Front pipeline: capture, products, sums
  logic             s1_v, s2_v, s3_v, s4_v;
  logic             s2_rdy, s3_rdy, s4_rdy;
  logic             div_start, div_take;
  div_status_t      st_s, st_m, st_h;

  logic [4:0]       s1_hr;
  logic [5:0]       s1_mn, s1_sc;
  logic [7:0]       s1_tk;

  logic [7:0]       t_eff;
  logic [4:0]       hr_mod;
  logic [5:0]       s2_mn;
  logic [4:0]       s2_hrm;
  logic [14:0]      s2_clk_s;
  logic [13:0]      s2_per_min;
  logic [19:0]      s2_per_hour;

  logic [14:0]      s3_clk_s;
  logic [19:0]      s3_clk_m;
  logic [13:0]      s3_per_min;
  logic [19:0]      s3_per_hour;
  logic [CLK_W-1:0] s3_hprod;
  logic [CLK_W-1:0] s3_span_h;

  logic [14:0]      s4_clk_s;
  logic [19:0]      s4_clk_m;
  logic [CLK_W-1:0] s4_clk_h;
  logic [13:0]      s4_per_min;
  logic [19:0]      s4_per_hour;
  logic [CLK_W-1:0] s4_span_h;

  logic div_idle, div_done;
  assign div_idle  = st_s.idle & st_m.idle & st_h.idle;
  assign div_done  = st_s.done & st_m.done & st_h.done;
  assign div_start = s4_v & div_idle;

  assign s4_rdy   = !s4_v || div_start;
  assign s3_rdy   = !s3_v || s4_rdy;
  assign s2_rdy   = !s2_v || s3_rdy;
  assign in_ready = !s1_v || s2_rdy;

  assign t_eff = (ticks_per_second == 8'd0) ? 8'd1 : ticks_per_second;

  // Hour modulo 12 or 24 for hours up to 31
  always_comb begin
    if (s1_hr >= 5'(HOURS_FULL)) begin
      hr_mod = s1_hr - 5'(HOURS_FULL);
    end else if (!day_mode && s1_hr >= 5'(HOURS_HALF)) begin
      hr_mod = s1_hr - 5'(HOURS_HALF);
    end else begin
      hr_mod = s1_hr;
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      if (in_ready) s1_v <= in_valid;
      if (s2_rdy)   s2_v <= s1_v;
      if (s3_rdy)   s3_v <= s2_v;
      if (s4_rdy)   s4_v <= s3_v;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_hr <= hour_of_day;
      s1_mn <= minute_of_hour;
      s1_sc <= second_of_minute;
      s1_tk <= tick_in_second;
    end
    if (s2_rdy) begin
      s2_mn       <= s1_mn;
      s2_hrm      <= hr_mod;
      s2_clk_s    <= 15'(s1_sc) * 15'(t_eff) + 15'(s1_tk);
      s2_per_min  <= 14'(t_eff) * 14'(SEC_PER_MIN);
      s2_per_hour <= 20'(t_eff) * 20'(SEC_PER_HOUR);
    end
    if (s3_rdy) begin
      s3_clk_s    <= s2_clk_s;
      s3_clk_m    <= 20'(s2_clk_s) + 20'(s2_mn) * 20'(s2_per_min);
      s3_per_min  <= s2_per_min;
      s3_per_hour <= s2_per_hour;
      s3_hprod    <= CLK_W'(s2_hrm) * CLK_W'(s2_per_hour);
      s3_span_h   <= CLK_W'(s2_per_hour) *
                     (day_mode ? CLK_W'(HOURS_FULL) : CLK_W'(HOURS_HALF));
    end
    if (s4_rdy) begin
      s4_clk_s    <= s3_clk_s;
      s4_clk_m    <= s3_clk_m;
      s4_clk_h    <= CLK_W'(s3_clk_m) + s3_hprod;
      s4_per_min  <= s3_per_min;
      s4_per_hour <= s3_per_hour;
      s4_span_h   <= s3_span_h;
    end
  end

  // Hand placement units
  logic [LED_W-1:0] d_pos_s, d_nxt_s, d_pos_m, d_nxt_m, d_pos_h, d_nxt_h;
  logic [LVL_W-1:0] d_lp_s, d_ln_s, d_lp_m, d_ln_m, d_lp_h, d_ln_h;

  lrc_hand_div u_div_s (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .take      (div_take),
    .clk_count (CLK_W'(s4_clk_s)),
    .span      (CLK_W'(s4_per_min)),
    .status    (st_s),
    .pos       (d_pos_s),
    .nxt       (d_nxt_s),
    .lvl_pos   (d_lp_s),
    .lvl_nxt   (d_ln_s)
  );

  lrc_hand_div u_div_m (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .take      (div_take),
    .clk_count (CLK_W'(s4_clk_m)),
    .span      (CLK_W'(s4_per_hour)),
    .status    (st_m),
    .pos       (d_pos_m),
    .nxt       (d_nxt_m),
    .lvl_pos   (d_lp_m),
    .lvl_nxt   (d_ln_m)
  );

  lrc_hand_div u_div_h (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .take      (div_take),
    .clk_count (s4_clk_h),
    .span      (s4_span_h),
    .status    (st_h),
    .pos       (d_pos_h),
    .nxt       (d_nxt_h),
    .lvl_pos   (d_lp_h),
    .lvl_nxt   (d_ln_h)
  );

  // Frame emitter: hold the hands of the frame being drawn
  logic             frame_active;
  logic [LED_W-1:0] idx;
  logic             pe;
  logic [LED_W-1:0] pos_s, nxt_s, pos_m, nxt_m, pos_h, nxt_h;
  logic [LVL_W-1:0] lp_s, ln_s, lp_m, ln_m, lp_h, ln_h;

  assign pe       = !out_valid || out_ready;
  assign div_take = !frame_active && div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active <= 1'b0;
      idx          <= '0;
    end else if (div_take) begin
      frame_active <= 1'b1;
      idx          <= '0;
    end else if (frame_active && pe) begin
      idx <= idx + 1'b1;
      if (idx == LED_W'(LED_COUNT - 1)) begin
        frame_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_take) begin
      pos_s <= d_pos_s; nxt_s <= d_nxt_s; lp_s <= d_lp_s; ln_s <= d_ln_s;
      pos_m <= d_pos_m; nxt_m <= d_nxt_m; lp_m <= d_lp_m; ln_m <= d_ln_m;
      pos_h <= d_pos_h; nxt_h <= d_nxt_h; lp_h <= d_lp_h; ln_h <= d_ln_h;
    end
  end

  // Per-pixel intensity of each hand
  logic [LVL_W-1:0] w_s, w_m, w_h, pk_sm, pk;

  always_comb begin
    w_s = (idx == pos_s) ? lp_s : ((idx == nxt_s) ? ln_s : '0);
    w_m = (idx == pos_m) ? lp_m : ((idx == nxt_m) ? ln_m : '0);
    w_h = (idx == pos_h) ? lp_h : ((idx == nxt_h) ? ln_h : '0);
    pk_sm = (w_s > w_m) ? w_s : w_m;
    pk    = (w_h > pk_sm) ? w_h : pk_sm;
  end

  // Pixel pipeline, stalled as a whole by the output register
  logic             pa_v, pb_v;
  logic [LED_W-1:0] pa_idx, pb_idx;
  logic             pa_last, pb_last;
  logic [LVL_W-1:0] pa_ws, pa_wm, pa_wh, pa_pk;
  logic [PRD_W-1:0] pb_ps, pb_pm, pb_ph;
  logic [VPR_W-1:0] pb_vp;

  logic [SUM_W-1:0] hsum;
  logic [HSH_W-1:0] hsh;
  logic [HUE_W-1:0] hue_mod;

  assign hsum = SUM_W'(pb_ps) + SUM_W'(pb_pm) + SUM_W'(pb_ph);
  assign hsh  = hsum[SUM_W-1:FRAC_BITS];

  // Reduce the hue modulo 360
  always_comb begin
    if (hsh >= HSH_W'(4 * HUE_WRAP)) begin
      hue_mod = HUE_W'(hsh - HSH_W'(4 * HUE_WRAP));
    end else if (hsh >= HSH_W'(3 * HUE_WRAP)) begin
      hue_mod = HUE_W'(hsh - HSH_W'(3 * HUE_WRAP));
    end else if (hsh >= HSH_W'(2 * HUE_WRAP)) begin
      hue_mod = HUE_W'(hsh - HSH_W'(2 * HUE_WRAP));
    end else if (hsh >= HSH_W'(HUE_WRAP)) begin
      hue_mod = HUE_W'(hsh - HSH_W'(HUE_WRAP));
    end else begin
      hue_mod = HUE_W'(hsh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_v      <= 1'b0;
      pb_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (pe) begin
      pa_v      <= frame_active;
      pb_v      <= pa_v;
      out_valid <= pb_v;
    end
  end

  always_ff @(posedge clk) begin
    if (pe) begin
      pa_idx  <= idx;
      pa_last <= (idx == LED_W'(LED_COUNT - 1));
      pa_ws   <= w_s;
      pa_wm   <= w_m;
      pa_wh   <= w_h;
      pa_pk   <= pk;

      pb_idx  <= pa_idx;
      pb_last <= pa_last;
      pb_ps   <= PRD_W'(pa_ws) * PRD_W'(second_hue);
      pb_pm   <= PRD_W'(pa_wm) * PRD_W'(minute_hue);
      pb_ph   <= PRD_W'(pa_wh) * PRD_W'(hour_hue);
      pb_vp   <= VPR_W'(pa_pk) * VPR_W'(peak_brightness);

      pixel_index      <= 6'(pb_idx);
      last_pixel       <= pb_last;
      hue              <= hue_mod;
      brightness_value <= pb_vp[FRAC_BITS+7:FRAC_BITS];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lrc_checker.sv =====
// Port-level checks for the LED ring clock hand renderer, bound to the top.
// Depends on lrc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lrc_checker import lrc_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] pixel_index,
  input wire logic [8:0] hue,
  input wire logic       last_pixel
);

  // Hold a stalled transaction
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "out_valid dropped while stalled")
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(pixel_index) && $stable(hue), "payload changed while stalled")

  // Frame marker sits on the final ring LED only
  `ASSERT_IMPLIES(a_last, clk, rst, out_valid, last_pixel == (pixel_index == 6'(LED_COUNT - 1)), "last_pixel mismatch")

  // Hue stays inside one turn
  `ASSERT_IMPLIES(a_hue, clk, rst, out_valid, hue < 9'(HUE_WRAP), "hue out of range")

  // Reset empties the output stage
  `ASSERT_NEXT(a_rst, clk, 1'b0, rst, !out_valid, "out_valid after reset")

endmodule

bind led_ring_clock_hand_renderer_unit lrc_checker u_lrc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .pixel_index (pixel_index),
  .hue         (hue),
  .last_pixel  (last_pixel)
);
`default_nettype wire
